>>> design/contact_impulse_resolver_macros.svh
// Assertion macros used by the contact impulse resolver top module.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef CONTACT_IMPULSE_RESOLVER_MACROS_SVH
`define CONTACT_IMPULSE_RESOLVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cir_pkg.sv
// Shared types, widths and helpers for the contact impulse resolver.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cir_pkg;

	localparam int VEL_W      = 32;
	localparam int MAG_W      = 31;
	localparam int DEN_W      = 32;
	localparam int FRAC_W     = 16;
	localparam int WIDE_W     = 48;
	localparam int MU_W       = 18;
	localparam int COEF_W     = 17;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int SH_W       = PROD_W - FRAC_W;
	localparam int NUM_C_W    = MAG_W + COEF_W;
	localparam int NUM_J_W    = MU_W + DEN_W;
	localparam int NUM_JT_W   = DEN_W + FRAC_W;
	localparam int IN_W       = 224;
	localparam int OUT_W      = 192;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int DIV_STEPS_DEF = 4;
	localparam int APPLY_LAT  = 3;

	localparam logic [COEF_W-1:0] RESTITUTION_RST = 17'd0;
	localparam logic [MU_W-1:0]   STATIC_MU_RST   = 18'd26214;
	localparam logic [MU_W-1:0]   DYNAMIC_MU_RST  = 18'd13107;
	localparam logic [COEF_W-1:0] CORRECTION_RST  = 17'd13107;
	localparam logic [COEF_W-1:0] SLOP_RST        = 17'd655;
	localparam logic [MU_W-1:0]   Q_ONE           = 18'd65536;

	typedef enum logic [1:0] {
		OUTCOME_APPLIED  = 2'd0,
		OUTCOME_SEPARATE = 2'd1,
		OUTCOME_STATIC   = 2'd2
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESTITUTION = 3'd0,
		REG_STATIC_MU   = 3'd1,
		REG_DYNAMIC_MU  = 3'd2,
		REG_CORRECTION  = 3'd3,
		REG_SLOP        = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [COEF_W-1:0] restitution;
		logic [MU_W-1:0]   static_mu;
		logic [MU_W-1:0]   dynamic_mu;
		logic [COEF_W-1:0] correction_percent;
		logic [COEF_W-1:0] penetration_slop;
	} cfg_t;

	typedef struct packed {
		logic              pad;
		logic [MAG_W-1:0]  penetration;
		logic [1:0]        normal_dir;
		logic [MAG_W-1:0]  inv_mass_b;
		logic [MAG_W-1:0]  inv_mass_a;
		logic [VEL_W-1:0]  vel_b_y;
		logic [VEL_W-1:0]  vel_b_x;
		logic [VEL_W-1:0]  vel_a_y;
		logic [VEL_W-1:0]  vel_a_x;
	} in_item_t;

	typedef struct packed {
		logic [VEL_W-1:0] shift_b;
		logic [VEL_W-1:0] shift_a;
		logic [VEL_W-1:0] new_vel_b_y;
		logic [VEL_W-1:0] new_vel_b_x;
		logic [VEL_W-1:0] new_vel_a_y;
		logic [VEL_W-1:0] new_vel_a_x;
	} out_item_t;

	// Per-contact context carried alongside the arithmetic.
	typedef struct packed {
		logic [VEL_W-1:0] va_x;
		logic [VEL_W-1:0] va_y;
		logic [VEL_W-1:0] vb_x;
		logic [VEL_W-1:0] vb_y;
		logic [MAG_W-1:0] ima;
		logic [MAG_W-1:0] imb;
		logic             ax;
		logic             pos;
		logic             sep;
		logic             both_static;
		logic             vt_neg;
		logic             vt_zero;
	} ctx_t;

	function automatic logic signed [WIDE_W-1:0] sext_wide(input logic [VEL_W-1:0] v);
		return signed'({{(WIDE_W-VEL_W){v[VEL_W-1]}}, v});
	endfunction

	function automatic logic signed [WIDE_W-1:0] zext_wide(input logic [SH_W-1:0] m);
		return signed'({{(WIDE_W-SH_W){1'b0}}, m});
	endfunction

	function automatic logic [VEL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic [VEL_W-1:0] r;
		if (v[WIDE_W-1:VEL_W-1] == '0 || v[WIDE_W-1:VEL_W-1] == '1) begin
			r = v[VEL_W-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(VEL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VEL_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> design/cir_div.sv
// Pipelined restoring divider with a quotient that saturates at 31 bits.
// Several quotient bits per stage; depends on cir_pkg.
`timescale 1ns / 1ps

module cir_div import cir_pkg::*; #(
	parameter int NUM_W = NUM_C_W,
	parameter int STEPS = DIV_STEPS_DEF
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [MAG_W-1:0] quo
);

	localparam int STAGES = (MAG_W + STEPS - 1) / STEPS;
	localparam int HI_W   = NUM_W - MAG_W;

	logic [DEN_W-1:0] rem_s  [STAGES];
	logic [MAG_W-1:0] work_s [STAGES];
	logic [DEN_W-1:0] den_s  [STAGES];
	logic             sat_s  [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam int LO  = k * STEPS;
		localparam int CNT = (MAG_W - LO < STEPS) ? (MAG_W - LO) : STEPS;

		logic [DEN_W-1:0] src_rem;
		logic [MAG_W-1:0] src_work;
		logic [DEN_W-1:0] src_den;
		logic             src_sat;
		logic [DEN_W-1:0] nxt_rem;
		logic [MAG_W-1:0] nxt_work;

		if (k == 0) begin : g_first
			always_comb begin
				src_rem  = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:MAG_W]};
				src_work = num[MAG_W-1:0];
				src_den  = den;
				src_sat  = src_rem >= den;
			end
		end else begin : g_next
			always_comb begin
				src_rem  = rem_s[k-1];
				src_work = work_s[k-1];
				src_den  = den_s[k-1];
				src_sat  = sat_s[k-1];
			end
		end

		always_comb begin
			logic [DEN_W:0] trial;
			logic           qbit;
			nxt_rem  = src_rem;
			nxt_work = src_work;
			for (int i = 0; i < CNT; i++) begin
				trial = {nxt_rem, nxt_work[MAG_W-1]};
				qbit  = trial >= {1'b0, src_den};
				if (qbit) begin
					trial = trial - {1'b0, src_den};
				end
				nxt_rem  = trial[DEN_W-1:0];
				nxt_work = {nxt_work[MAG_W-2:0], qbit};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= nxt_rem;
				work_s[k] <= nxt_work;
				den_s[k]  <= src_den;
				sat_s[k]  <= src_sat;
			end
		end
	end

	assign quo = sat_s[STAGES-1] ? {MAG_W{1'b1}} : work_s[STAGES-1];

endmodule

>>> design/cir_front.sv
// Front stages: contact decode, relative velocities and divider numerators.
// Two register stages; depends on cir_pkg.
`timescale 1ns / 1ps

module cir_front import cir_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  in_item_t            item,
	input  cfg_t                cfg,
	output ctx_t                ctx_s2,
	output logic [DEN_W-1:0]    imsum_s2,
	output logic [NUM_C_W-1:0]  num_c_s2,
	output logic [NUM_J_W-1:0]  num_j_s2,
	output logic [NUM_JT_W-1:0] num_jt_s2
);

	ctx_t             ctx_d;
	logic [VEL_W-1:0] va_n, vb_n, va_t, vb_t;
	logic signed [VEL_W+1:0] diff, vn, nvn;
	logic signed [VEL_W:0]   vt, avt_w;
	logic [DEN_W-1:0] imsum_d;
	logic [MAG_W-1:0] pen_d;

	ctx_t             ctx_s1;
	logic [DEN_W-1:0] imsum_s1;
	logic [MAG_W-1:0] pen_s1;
	logic [DEN_W-1:0] negvn_s1;
	logic [DEN_W-1:0] avt_s1;

	always_comb begin
		va_n = item.normal_dir[1] ? item.vel_a_y : item.vel_a_x;
		vb_n = item.normal_dir[1] ? item.vel_b_y : item.vel_b_x;
		va_t = item.normal_dir[1] ? item.vel_a_x : item.vel_a_y;
		vb_t = item.normal_dir[1] ? item.vel_b_x : item.vel_b_y;
		diff = signed'({{2{vb_n[VEL_W-1]}}, vb_n}) - signed'({{2{va_n[VEL_W-1]}}, va_n});
		vn   = item.normal_dir[0] ? diff : -diff;
		nvn  = -vn;
		vt   = signed'({vb_t[VEL_W-1], vb_t}) - signed'({va_t[VEL_W-1], va_t});
		avt_w = vt[VEL_W] ? -vt : vt;
		imsum_d = {1'b0, item.inv_mass_a} + {1'b0, item.inv_mass_b};
		if (item.penetration > {{(MAG_W-COEF_W){1'b0}}, cfg.penetration_slop}) begin
			pen_d = item.penetration - {{(MAG_W-COEF_W){1'b0}}, cfg.penetration_slop};
		end else begin
			pen_d = '0;
		end
		ctx_d.va_x        = item.vel_a_x;
		ctx_d.va_y        = item.vel_a_y;
		ctx_d.vb_x        = item.vel_b_x;
		ctx_d.vb_y        = item.vel_b_y;
		ctx_d.ima         = item.inv_mass_a;
		ctx_d.imb         = item.inv_mass_b;
		ctx_d.ax          = item.normal_dir[1];
		ctx_d.pos         = item.normal_dir[0];
		ctx_d.sep         = !vn[VEL_W+1] && (vn != '0);
		ctx_d.both_static = imsum_d == '0;
		ctx_d.vt_neg      = vt[VEL_W];
		ctx_d.vt_zero     = vt == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1   <= ctx_d;
			imsum_s1 <= imsum_d;
			pen_s1   <= pen_d;
			negvn_s1 <= nvn[DEN_W-1:0];
			avt_s1   <= avt_w[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2    <= ctx_s1;
			imsum_s2  <= imsum_s1;
			num_c_s2  <= NUM_C_W'(pen_s1) * NUM_C_W'(cfg.correction_percent);
			num_j_s2  <= NUM_J_W'({1'b0, cfg.restitution} + Q_ONE) * NUM_J_W'(negvn_s1);
			num_jt_s2 <= {avt_s1, {FRAC_W{1'b0}}};
		end
	end

endmodule

>>> design/cir_apply.sv
// Back stages: impulse products, friction choice, velocity update and saturation.
// Three register stages and a combinational result; depends on cir_pkg.
`timescale 1ns / 1ps

module cir_apply import cir_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  cfg_t             cfg,
	input  ctx_t             ctx,
	input  logic [MAG_W-1:0] c,
	input  logic [MAG_W-1:0] j,
	input  logic [MAG_W-1:0] jt,
	output out_item_t        result,
	output outcome_t         outcome
);

	localparam int MP_W = MAG_W + MU_W;

	logic [PROD_W-1:0] p_ca, p_cb, p_ja, p_jb, p_fa, p_fb;
	logic [MP_W-1:0]   p_s, p_d;

	ctx_t             ctx_s1;
	logic [MAG_W-1:0] jt_s1;
	logic [SH_W-1:0]  sha_m_s1, shb_m_s1, jna_s1, jnb_s1;
	logic [MP_W-1:0]  sprod_s1, dprod_s1;

	logic signed [WIDE_W-1:0] va_n_w, vb_n_w, jna_w, jnb_w, sha_w, shb_w;
	logic [MAG_W-1:0] f_d, dyn_d;

	ctx_t                     ctx_s2;
	logic signed [WIDE_W-1:0] va_n_s2, vb_n_s2, sha_s2, shb_s2;
	logic [MAG_W-1:0]         f_s2;

	ctx_t                     ctx_s3;
	logic signed [WIDE_W-1:0] va_n_s3, vb_n_s3, sha_s3, shb_s3;
	logic [SH_W-1:0]          fa_s3, fb_s3;

	logic signed [WIDE_W-1:0] va_t_w, vb_t_w, fa_w, fb_w;

	always_comb begin
		p_ca = PROD_W'(c) * PROD_W'(ctx.ima);
		p_cb = PROD_W'(c) * PROD_W'(ctx.imb);
		p_ja = PROD_W'(j) * PROD_W'(ctx.ima);
		p_jb = PROD_W'(j) * PROD_W'(ctx.imb);
		p_s  = MP_W'(j) * MP_W'(cfg.static_mu);
		p_d  = MP_W'(j) * MP_W'(cfg.dynamic_mu);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1   <= ctx;
			jt_s1    <= jt;
			sha_m_s1 <= p_ca[PROD_W-1:FRAC_W];
			shb_m_s1 <= p_cb[PROD_W-1:FRAC_W];
			jna_s1   <= p_ja[PROD_W-1:FRAC_W];
			jnb_s1   <= p_jb[PROD_W-1:FRAC_W];
			sprod_s1 <= p_s;
			dprod_s1 <= p_d;
		end
	end

	always_comb begin
		va_n_w = sext_wide(ctx_s1.ax ? ctx_s1.va_y : ctx_s1.va_x);
		vb_n_w = sext_wide(ctx_s1.ax ? ctx_s1.vb_y : ctx_s1.vb_x);
		jna_w  = zext_wide(jna_s1);
		jnb_w  = zext_wide(jnb_s1);
		sha_w  = zext_wide(sha_m_s1);
		shb_w  = zext_wide(shb_m_s1);
		if (|dprod_s1[MP_W-1:MAG_W+FRAC_W]) begin
			dyn_d = {MAG_W{1'b1}};
		end else begin
			dyn_d = dprod_s1[MAG_W+FRAC_W-1:FRAC_W];
		end
		if (MP_W'({jt_s1, {FRAC_W{1'b0}}}) < sprod_s1) begin
			f_d = jt_s1;
		end else begin
			f_d = dyn_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2  <= ctx_s1;
			va_n_s2 <= ctx_s1.pos ? va_n_w - jna_w : va_n_w + jna_w;
			vb_n_s2 <= ctx_s1.pos ? vb_n_w + jnb_w : vb_n_w - jnb_w;
			sha_s2  <= ctx_s1.pos ? -sha_w : sha_w;
			shb_s2  <= ctx_s1.pos ? shb_w : -shb_w;
			f_s2    <= f_d;
		end
	end

	always_comb begin
		p_fa = PROD_W'(f_s2) * PROD_W'(ctx_s2.ima);
		p_fb = PROD_W'(f_s2) * PROD_W'(ctx_s2.imb);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3  <= ctx_s2;
			va_n_s3 <= va_n_s2;
			vb_n_s3 <= vb_n_s2;
			sha_s3  <= sha_s2;
			shb_s3  <= shb_s2;
			fa_s3   <= p_fa[PROD_W-1:FRAC_W];
			fb_s3   <= p_fb[PROD_W-1:FRAC_W];
		end
	end

	always_comb begin
		va_t_w = sext_wide(ctx_s3.ax ? ctx_s3.va_x : ctx_s3.va_y);
		vb_t_w = sext_wide(ctx_s3.ax ? ctx_s3.vb_x : ctx_s3.vb_y);
		fa_w   = zext_wide(fa_s3);
		fb_w   = zext_wide(fb_s3);
		if (!ctx_s3.vt_zero) begin
			va_t_w = ctx_s3.vt_neg ? va_t_w - fa_w : va_t_w + fa_w;
			vb_t_w = ctx_s3.vt_neg ? vb_t_w + fb_w : vb_t_w - fb_w;
		end

		result.new_vel_a_x = ctx_s3.va_x;
		result.new_vel_a_y = ctx_s3.va_y;
		result.new_vel_b_x = ctx_s3.vb_x;
		result.new_vel_b_y = ctx_s3.vb_y;
		result.shift_a     = sat32(sha_s3);
		result.shift_b     = sat32(shb_s3);
		if (ctx_s3.both_static) begin
			outcome        = OUTCOME_STATIC;
			result.shift_a = '0;
			result.shift_b = '0;
		end else if (ctx_s3.sep) begin
			outcome = OUTCOME_SEPARATE;
		end else begin
			outcome            = OUTCOME_APPLIED;
			result.new_vel_a_x = sat32(ctx_s3.ax ? va_t_w : va_n_s3);
			result.new_vel_a_y = sat32(ctx_s3.ax ? va_n_s3 : va_t_w);
			result.new_vel_b_x = sat32(ctx_s3.ax ? vb_t_w : vb_n_s3);
			result.new_vel_b_y = sat32(ctx_s3.ax ? vb_n_s3 : vb_t_w);
		end
	end

endmodule

>>> design/contact_impulse_resolver.sv
// An input contact passes the front, divider and apply stages and then the output register.
// Throughput: one contact per cycle unless stalled; the three dividers are pipelined, DIV_STEPS bits a stage.
// The whole pipeline advances when the output register is empty or its result is taken.
// Reset clears every valid bit and loads the coefficient registers with their defaults.
`timescale 1ns / 1ps
`include "contact_impulse_resolver_macros.svh"

module contact_impulse_resolver import cir_pkg::*; #(
	parameter int DIV_STEPS = DIV_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// vel_a_x, vel_a_y, vel_b_x, vel_b_y, inv_mass_a, inv_mass_b, normal_dir, penetration
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, shift_a, shift_b
	output logic [OUT_W-1:0]      m_axis_tdata,
	// outcome
	output logic [1:0]            m_axis_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DIV_LAT = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int PIPE_D  = 2 + DIV_LAT + APPLY_LAT;

	logic en;
	cfg_t cfg_q;
	logic [PIPE_D-1:0] vld_q;
	ctx_t ctx_dly_q [DIV_LAT];

	ctx_t                ctx_s2;
	logic [DEN_W-1:0]    imsum_s2;
	logic [NUM_C_W-1:0]  num_c_s2;
	logic [NUM_J_W-1:0]  num_j_s2;
	logic [NUM_JT_W-1:0] num_jt_s2;
	logic [MAG_W-1:0]    c_q, j_q, jt_q;
	out_item_t           result;
	outcome_t            outcome;
	out_item_t           out_data_q;
	outcome_t            out_user_q;
	logic                out_vld_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.restitution        <= RESTITUTION_RST;
			cfg_q.static_mu          <= STATIC_MU_RST;
			cfg_q.dynamic_mu         <= DYNAMIC_MU_RST;
			cfg_q.correction_percent <= CORRECTION_RST;
			cfg_q.penetration_slop   <= SLOP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RESTITUTION: cfg_q.restitution        <= cfg_wdata[COEF_W-1:0];
				REG_STATIC_MU:   cfg_q.static_mu          <= cfg_wdata[MU_W-1:0];
				REG_DYNAMIC_MU:  cfg_q.dynamic_mu         <= cfg_wdata[MU_W-1:0];
				REG_CORRECTION:  cfg_q.correction_percent <= cfg_wdata[COEF_W-1:0];
				REG_SLOP:        cfg_q.penetration_slop   <= cfg_wdata[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[PIPE_D-2:0], s_axis_tvalid};
			out_vld_q <= vld_q[PIPE_D-1];
		end
	end

	cir_front u_front (
		.clk       (clk),
		.en        (en),
		.item      (in_item_t'(s_axis_tdata)),
		.cfg       (cfg_q),
		.ctx_s2    (ctx_s2),
		.imsum_s2  (imsum_s2),
		.num_c_s2  (num_c_s2),
		.num_j_s2  (num_j_s2),
		.num_jt_s2 (num_jt_s2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_dly_q[0] <= ctx_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				ctx_dly_q[i] <= ctx_dly_q[i-1];
			end
		end
	end

	cir_div #(.NUM_W(NUM_C_W), .STEPS(DIV_STEPS)) u_div_c (
		.clk (clk), .en (en), .num (num_c_s2), .den (imsum_s2), .quo (c_q)
	);

	cir_div #(.NUM_W(NUM_J_W), .STEPS(DIV_STEPS)) u_div_j (
		.clk (clk), .en (en), .num (num_j_s2), .den (imsum_s2), .quo (j_q)
	);

	cir_div #(.NUM_W(NUM_JT_W), .STEPS(DIV_STEPS)) u_div_jt (
		.clk (clk), .en (en), .num (num_jt_s2), .den (imsum_s2), .quo (jt_q)
	);

	cir_apply u_apply (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg_q),
		.ctx     (ctx_dly_q[DIV_LAT-1]),
		.c       (c_q),
		.j       (j_q),
		.jt      (jt_q),
		.result  (result),
		.outcome (outcome)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= result;
			out_user_q <= outcome;
		end
	end

	`CIR_ASSERT_NOW(a_static_no_shift, m_axis_tvalid && m_axis_tuser == OUTCOME_STATIC, out_data_q.shift_a == '0 && out_data_q.shift_b == '0, "static contact with nonzero shift")
	`CIR_ASSERT_NOW(a_frozen_no_accept, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while pipeline is frozen")
	`CIR_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted contact lost at pipeline entry")
	`CIR_ASSERT_NEXT(a_no_phantom, s_axis_tready && !vld_q[PIPE_D-1], !m_axis_tvalid, "result appeared without a contact behind it")

endmodule
